>>> src/c2p_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to polar package
// Types, fixed widths and constants shared by the cartesian to polar block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

    // width of one input component
    localparam int COMPONENT_WIDTH = 16;

    // CORDIC set-up
    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 24;   // angle and component fraction bits
    localparam int ANGLE_W      = 28;   // angle accumulator width
    localparam int PHASE_W      = 16;
    localparam int MAG_W        = 16;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24     = 28'sd26353589;
    localparam logic signed [ANGLE_W-1:0] NEG_HALF_PI_Q24 = -28'sd26353589;

    // Q3.13 output angles
    localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI     = 16'sd12868;
    localparam logic signed [PHASE_W-1:0] PHASE_NEG_HALF_PI = -16'sd12868;
    localparam logic signed [PHASE_W-1:0] PHASE_PI          = 16'sd25736;

    // Q24 -> Q13 rounding
    localparam int PHASE_SHIFT = FRAC_BITS - 13;
    localparam logic signed [ANGLE_W-1:0] PHASE_ROUND = 28'sd1024;

    localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] vec_x;
        logic signed [COMPONENT_WIDTH-1:0] vec_y;
    } c2p_cart_t;

    typedef struct packed {
        logic signed [PHASE_W-1:0] phase;
        logic        [MAG_W-1:0]   magnitude;
        logic                      zero_vector;
    } c2p_polar_t;

    // atan(2^-i) in units of 2^-24, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] a;
        case (idx)
            5'd0:    a = 28'sd13176795;
            5'd1:    a = 28'sd7778716;
            5'd2:    a = 28'sd4110060;
            5'd3:    a = 28'sd2086331;
            5'd4:    a = 28'sd1047214;
            5'd5:    a = 28'sd524117;
            5'd6:    a = 28'sd262123;
            5'd7:    a = 28'sd131069;
            5'd8:    a = 28'sd65536;
            5'd9:    a = 28'sd32768;
            5'd10:   a = 28'sd16384;
            5'd11:   a = 28'sd8192;
            5'd12:   a = 28'sd4096;
            5'd13:   a = 28'sd2048;
            5'd14:   a = 28'sd1024;
            5'd15:   a = 28'sd512;
            5'd16:   a = 28'sd256;
            5'd17:   a = 28'sd128;
            5'd18:   a = 28'sd64;
            5'd19:   a = 28'sd32;
            5'd20:   a = 28'sd16;
            5'd21:   a = 28'sd8;
            5'd22:   a = 28'sd4;
            5'd23:   a = 28'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> src/cartesian_to_polar_top.sv
// ----------------------------------------------------------------------------
// Cartesian to polar converter
// Pipeline depth is set by the 24 CORDIC rotation stages.
// Throughput: one request per cycle; the whole pipeline holds while the
//   output register is full and stalled.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cart_valid,
    output logic                  cart_stall,
    input  c2p_pkg::c2p_cart_t    cart,
    output logic                  polar_valid,
    input  logic                  polar_stall,
    output c2p_pkg::c2p_polar_t   polar
);
    import c2p_pkg::*;

    localparam int W    = COMPONENT_WIDTH;
    localparam int CW   = W + 1 + FRAC_BITS + 2;  // CORDIC x/y width with gain headroom
    localparam int ZW   = ANGLE_W;
    localparam int SW   = 2 * W;                  // x*x + y*y
    localparam int NSTG = (W + 3 > CORDIC_STEPS + 1) ? W + 3 : CORDIC_STEPS + 1;
    localparam int L    = NSTG - 1;
    localparam int MXW  = (W + 1 > MAG_W + 1) ? W + 1 : MAG_W + 1;

    localparam logic signed [ZW-1:0] PH_HI = ZW'(PHASE_PI);
    localparam logic signed [ZW-1:0] PH_LO = -PH_HI;

    logic en;

    logic                       valid_reg    [0:L];
    logic signed [CW-1:0]       cx_reg       [0:L];
    logic signed [CW-1:0]       cx_next      [0:L];
    logic signed [CW-1:0]       cy_reg       [0:L];
    logic signed [CW-1:0]       cy_next      [0:L];
    logic signed [ZW-1:0]       cz_reg       [0:L];
    logic signed [ZW-1:0]       cz_next      [0:L];
    logic [SW-1:0]              rem_reg      [0:L];
    logic [SW-1:0]              rem_next     [0:L];
    logic [W-1:0]               root_reg     [0:L];
    logic [W-1:0]               root_next    [0:L];
    logic                       special_reg  [0:L];
    logic signed [PHASE_W-1:0]  sp_phase_reg [0:L];
    logic                       zero_reg     [0:L];

    logic [W-1:0]               ax_reg, ax_next;
    logic [W-1:0]               ay_reg, ay_next;
    logic [SW-1:0]              sq_x_reg, sq_x_next;
    logic [SW-1:0]              sq_y_reg, sq_y_next;
    logic                       special_next;
    logic signed [PHASE_W-1:0]  sp_phase_next;
    logic                       zero_next;

    logic                       polar_valid_reg;
    c2p_polar_t                 polar_reg, polar_next;

    // whole pipeline moves unless the output register is full and stalled
    assign en          = !(polar_valid_reg && polar_stall);
    assign cart_stall  = !en;
    assign polar_valid = polar_valid_reg;
    assign polar       = polar_reg;

    // ------------------------------------------------------------------
    // stage 0: magnitudes, special cases, quadrant pre-rotation
    // ------------------------------------------------------------------
    logic signed [W:0]          xe, ye, nx, ny, px, py;
    logic signed [ZW-1:0]       pz;
    logic                       x_zero, y_zero;

    always_comb
    begin
        xe     = {cart.vec_x[W-1], cart.vec_x};
        ye     = {cart.vec_y[W-1], cart.vec_y};
        nx     = -xe;
        ny     = -ye;
        x_zero = (cart.vec_x == '0);
        y_zero = (cart.vec_y == '0);

        ax_next = xe[W] ? nx[W-1:0] : xe[W-1:0];
        ay_next = ye[W] ? ny[W-1:0] : ye[W-1:0];

        zero_next    = x_zero && y_zero;
        special_next = x_zero || y_zero;
        if (x_zero)
        begin
            if (y_zero)
                sp_phase_next = '0;
            else if (ye[W])
                sp_phase_next = PHASE_NEG_HALF_PI;
            else
                sp_phase_next = PHASE_HALF_PI;
        end
        else if (xe[W])
        begin
            sp_phase_next = PHASE_PI;
        end
        else
        begin
            sp_phase_next = '0;
        end

        // left half plane: turn by -pi/2 or +pi/2 into the right half
        if (xe[W])
        begin
            if (!ye[W])
            begin
                px = ye;
                py = nx;
                pz = HALF_PI_Q24;
            end
            else
            begin
                px = ny;
                py = xe;
                pz = NEG_HALF_PI_Q24;
            end
        end
        else
        begin
            px = xe;
            py = ye;
            pz = '0;
        end

        cx_next[0]   = {{2{px[W]}}, px, {FRAC_BITS{1'b0}}};
        cy_next[0]   = {{2{py[W]}}, py, {FRAC_BITS{1'b0}}};
        cz_next[0]   = pz;
        rem_next[0]  = '0;
        root_next[0] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= cart_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]       <= cx_next[0];
            cy_reg[0]       <= cy_next[0];
            cz_reg[0]       <= cz_next[0];
            rem_reg[0]      <= rem_next[0];
            root_reg[0]     <= root_next[0];
            special_reg[0]  <= special_next;
            sp_phase_reg[0] <= sp_phase_next;
            zero_reg[0]     <= zero_next;
            ax_reg          <= ax_next;
            ay_reg          <= ay_next;
        end
    end

    // squares, registered before the sum in stage 2
    assign sq_x_next = ax_reg * ax_reg;
    assign sq_y_next = ay_reg * ay_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
        end
    end

    // ------------------------------------------------------------------
    // stages 1..L: CORDIC rotation i at stage i+1, root bit b at stage W+2-b
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= L; k++)
    begin : g_stage
        if (k <= CORDIC_STEPS)
        begin : g_rot
            localparam int SH = k - 1;
            logic signed [CW-1:0] dx, dy;
            always_comb
            begin
                dx = cy_reg[k-1] >>> SH;
                dy = cx_reg[k-1] >>> SH;
                if (cy_reg[k-1] > 0)
                begin
                    cx_next[k] = cx_reg[k-1] + dx;
                    cy_next[k] = cy_reg[k-1] - dy;
                    cz_next[k] = cz_reg[k-1] + atan_q24(5'(SH));
                end
                else
                begin
                    cx_next[k] = cx_reg[k-1] - dx;
                    cy_next[k] = cy_reg[k-1] + dy;
                    cz_next[k] = cz_reg[k-1] - atan_q24(5'(SH));
                end
            end
        end
        else
        begin : g_rot_pass
            assign cx_next[k] = cx_reg[k-1];
            assign cy_next[k] = cy_reg[k-1];
            assign cz_next[k] = cz_reg[k-1];
        end

        if (k == 2)
        begin : g_sum
            assign rem_next[k]  = sq_x_reg + sq_y_reg;
            assign root_next[k] = '0;
        end
        else if (k >= 3 && k <= W + 2)
        begin : g_root
            localparam int B = W + 2 - k;
            logic [SW:0] remx, trial, diff;
            always_comb
            begin
                // (root + 2^B)^2 - root^2
                remx  = {1'b0, rem_reg[k-1]};
                trial = ({{(SW + 1 - W){1'b0}}, root_reg[k-1]} << (B + 1))
                        + ((SW + 1)'(1) << (2 * B));
                diff  = remx - trial;
                if (remx >= trial)
                begin
                    rem_next[k]  = diff[SW-1:0];
                    root_next[k] = root_reg[k-1] | (W'(1) << B);
                end
                else
                begin
                    rem_next[k]  = rem_reg[k-1];
                    root_next[k] = root_reg[k-1];
                end
            end
        end
        else
        begin : g_root_pass
            assign rem_next[k]  = rem_reg[k-1];
            assign root_next[k] = root_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[k]       <= cx_next[k];
                cy_reg[k]       <= cy_next[k];
                cz_reg[k]       <= cz_next[k];
                rem_reg[k]      <= rem_next[k];
                root_reg[k]     <= root_next[k];
                special_reg[k]  <= special_reg[k-1];
                sp_phase_reg[k] <= sp_phase_reg[k-1];
                zero_reg[k]     <= zero_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: phase rounding and clamp, magnitude rounding
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] zr, zc;
    logic [W:0]           mr;
    logic [MXW-1:0]       mx;

    always_comb
    begin
        zr = (cz_reg[L] + PHASE_ROUND) >>> PHASE_SHIFT;
        if (zr > PH_HI)
            zc = PH_HI;
        else if (zr < PH_LO)
            zc = PH_LO;
        else
            zc = zr;

        // remainder is s - root^2; round up when it exceeds root
        if (rem_reg[L] > SW'(root_reg[L]))
            mr = {1'b0, root_reg[L]} + (W + 1)'(1);
        else
            mr = {1'b0, root_reg[L]};
        mx = MXW'(mr);

        polar_next.phase       = special_reg[L] ? sp_phase_reg[L] : zc[PHASE_W-1:0];
        polar_next.magnitude   = (mx > MXW'(MAG_MAX)) ? MAG_MAX : mx[MAG_W-1:0];
        polar_next.zero_vector = zero_reg[L];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            polar_valid_reg <= 1'b0;
        else if (en)
            polar_valid_reg <= valid_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            polar_reg <= polar_next;
    end

endmodule

`default_nettype wire

>>> verif/cartesian_to_polar_top_tb.sv
// ----------------------------------------------------------------------------
// Cartesian to polar converter testbench
// Sends vector requests through the valid/stall handshake and compares each
// phase, magnitude and zero flag against a CORDIC vectoring predictor. A short
// table of edge vectors comes first, then bursts of random requests. The
// receiver stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module cartesian_to_polar_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2p_pkg::*;

    localparam int NUM_DIR        = 23;
    localparam int NUM_RAND       = 1330;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [COMPONENT_WIDTH-1:0] CMAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
    localparam logic signed [COMPONENT_WIDTH-1:0] CMIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

    // Q24 rotation constants and Q3.13 axis angles
    localparam longint ROT_HALF_PI = 26353589;
    localparam longint Q13_HALF_PI = 12868;
    localparam longint Q13_PI      = 25736;
    localparam longint MAG_SAT     = 65535;
    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        c2p_cart_t  vec;
        logic       fixed_exp;
        c2p_polar_t res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cart_valid;
    logic       cart_stall;
    c2p_cart_t  cart;
    logic       polar_valid;
    logic       polar_stall;
    c2p_polar_t polar;

    c2p_polar_t pending_polar [$];
    int         mismatch_cnt = 0;
    int         accepted_cnt = 0;
    int         idle_cycles  = 0;

    cartesian_to_polar_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cart_valid  (cart_valid),
        .cart_stall  (cart_stall),
        .cart        (cart),
        .polar_valid (polar_valid),
        .polar_stall (polar_stall),
        .polar       (polar)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic c2p_polar_t polar_of(input c2p_cart_t c);
        longint     x0, y0, x, y, z, dx, dy, sq, rem, root, b;
        int         i;
        c2p_polar_t r;
        x0 = longint'($signed(c.vec_x));
        y0 = longint'($signed(c.vec_y));

        // bitwise integer square root, then round to nearest
        sq   = x0 * x0 + y0 * y0;
        rem  = sq;
        root = 0;
        b    = longint'(1) <<< 62;
        while (b > rem)
            b = b >>> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - root - b;
                root = (root >>> 1) + b;
            end
            else
            begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        if (sq - root * root > root)
            root++;
        if (root > MAG_SAT)
            root = MAG_SAT;

        if (x0 == 0 && y0 == 0)
            z = 0;
        else if (x0 == 0)
            z = (y0 > 0) ? Q13_HALF_PI : -Q13_HALF_PI;
        else if (y0 == 0)
            z = (x0 > 0) ? 0 : Q13_PI;
        else
        begin
            // left half plane: pre-rotate by a quarter turn
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x = y0;
                    y = -x0;
                    z = ROT_HALF_PI;
                end
                else
                begin
                    x = -y0;
                    y = x0;
                    z = -ROT_HALF_PI;
                end
            end
            else
            begin
                x = x0;
                y = y0;
                z = 0;
            end
            x = x <<< 24;
            y = y <<< 24;
            for (i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_Q24[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_Q24[i];
                end
            end
            z = (z + 1024) >>> 11;
            if (z > Q13_PI)
                z = Q13_PI;
            if (z < -Q13_PI)
                z = -Q13_PI;
        end

        r.phase       = 16'(z);
        r.magnitude   = 16'(root);
        r.zero_vector = (x0 == 0 && y0 == 0);
        return r;
    endfunction

    function automatic logic signed [COMPONENT_WIDTH-1:0] pick_component();
        logic signed [COMPONENT_WIDTH-1:0] v;
        v = COMPONENT_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            0: v = CMIN;
            1: v = CMAX;
            2:
            begin
                v = COMPONENT_WIDTH'($urandom_range(0, 8));
                v = v - COMPONENT_WIDTH'(4);
            end
            3: v = v >>> $urandom_range(1, COMPONENT_WIDTH - 1);
            default: ;
        endcase
        return v;
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic offer(input c2p_cart_t item, input c2p_polar_t want);
        logic taken;
        cart       <= item;
        cart_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !cart_stall;
            if (taken)
                pending_polar.push_back(want);
            @(posedge clk);
        end
        accepted_cnt++;
    endtask

    initial
    begin : stimulus
        stim_row_t  dir_tab [NUM_DIR];
        c2p_cart_t  item;
        c2p_polar_t want;
        int         burst, gap, sent, sel;

        cart_valid <= 1'b0;
        cart       <= '0;
        rst_n      <= 1'b0;

        // vec, fixed_exp, {phase, magnitude, zero_vector}
        dir_tab = '{
            '{'{16'sd0, 16'sd0},   1'b1, '{16'sd0, 16'd0, 1'b1}},
            '{'{16'sd0, 16'sd1},   1'b1, '{16'sd12868, 16'd1, 1'b0}},
            '{'{16'sd0, -16'sd1},  1'b1, '{-16'sd12868, 16'd1, 1'b0}},
            '{'{16'sd0, CMAX},     1'b1, '{16'sd12868, 16'd32767, 1'b0}},
            '{'{16'sd0, CMIN},     1'b1, '{-16'sd12868, 16'd32768, 1'b0}},
            '{'{16'sd1, 16'sd0},   1'b1, '{16'sd0, 16'd1, 1'b0}},
            '{'{-16'sd1, 16'sd0},  1'b1, '{16'sd25736, 16'd1, 1'b0}},
            '{'{CMAX, 16'sd0},     1'b1, '{16'sd0, 16'd32767, 1'b0}},
            '{'{CMIN, 16'sd0},     1'b1, '{16'sd25736, 16'd32768, 1'b0}},
            '{'{CMIN, CMIN},       1'b0, '0},
            '{'{CMAX, CMAX},       1'b0, '0},
            '{'{CMIN, CMAX},       1'b0, '0},
            '{'{CMAX, CMIN},       1'b0, '0},
            '{'{16'sd1, 16'sd1},   1'b0, '0},
            '{'{-16'sd1, -16'sd1}, 1'b0, '0},
            '{'{16'sd1, -16'sd1},  1'b0, '0},
            '{'{-16'sd1, 16'sd1},  1'b0, '0},
            '{'{CMIN, -16'sd1},    1'b0, '0},
            '{'{CMIN, 16'sd1},     1'b0, '0},
            '{'{-16'sd1, CMIN},    1'b0, '0},
            '{'{16'sd3, 16'sd4},   1'b0, '0},
            '{'{CMAX, 16'sd1},     1'b0, '0},
            '{'{-16'sd3, -16'sd4}, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            want = dir_tab[k].fixed_exp ? dir_tab[k].res : polar_of(dir_tab[k].vec);
            offer(dir_tab[k].vec, want);
        end

        sent = 0;
        while (sent < NUM_RAND)
        begin
            burst = $urandom_range(1, 48);
            repeat (burst)
            begin
                item.vec_x = pick_component();
                item.vec_y = pick_component();
                sel = $urandom_range(0, 19);
                case (sel)
                    0: item.vec_x = '0;
                    1: item.vec_y = '0;
                    2: item.vec_y = item.vec_x;
                    3: item.vec_y = -item.vec_x;
                    default: ;
                endcase
                offer(item, polar_of(item));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cart_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cart_valid <= 1'b0;

        while (pending_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : receiver
        int   seg_left, mode;
        logic hold_done;
        seg_left  = 0;
        mode      = 0;
        hold_done = 1'b0;
        polar_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // one long hold-off so the pipeline backs up into the input
            if (!hold_done && accepted_cnt >= HOLD_AT)
            begin
                polar_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 160);
            end
            seg_left--;
            case (mode)
                0: polar_stall <= 1'b0;
                1: polar_stall <= ($urandom_range(0, 3) == 0);
                2: polar_stall <= 1'($urandom_range(0, 1));
                default: polar_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // outputs only move on the rising edge, so the falling edge sees
    // exactly what the next rising edge will take
    always @(negedge clk)
    begin : result_check
        c2p_polar_t want;
        if (rst_n && polar_valid && !polar_stall)
        begin
            if (pending_polar.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: phase=%0d mag=%0d zero=%0b",
                             polar.phase, polar.magnitude, polar.zero_vector);
            end
            else
            begin
                want = pending_polar.pop_front();
                if (polar.phase !== want.phase || polar.magnitude !== want.magnitude ||
                    polar.zero_vector !== want.zero_vector)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b",
                                 want.phase, want.magnitude, want.zero_vector,
                                 polar.phase, polar.magnitude, polar.zero_vector);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((cart_valid && !cart_stall) || (polar_valid && !polar_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

endmodule
